/* rtl/core/dicpg_pkg.sv */
// shared types, constants and sizes for the decoded instruction cache
`timescale 1ns / 1ps
package dicpg_pkg;

    localparam int CACHE_ENTRIES = 1024;
    localparam int PAGE_SHIFT    = 12;
    localparam int MAX_PAGES     = 256;
    localparam int PAYLOAD_WIDTH = 64;

    localparam int EW      = $clog2(CACHE_ENTRIES);
    localparam int PW      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int NW      = $clog2(MAX_PAGES + 1);
    localparam int PGW     = 32 - PAGE_SHIFT;
    localparam int CLR_LEN = (CACHE_ENTRIES > MAX_PAGES) ? CACHE_ENTRIES : MAX_PAGES;
    localparam int CW      = $clog2(CLR_LEN);

    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_STORE  = 2'd1;
    localparam logic [1:0] KIND_WRITE  = 2'd2;

    localparam logic CFG_PAGE_BASE  = 1'b0;
    localparam logic CFG_PAGE_COUNT = 1'b1;

    localparam logic [2:0]  LEN_WORD = 3'd4;
    localparam logic [31:0] PC_HALF  = 32'd2;
    localparam logic [31:0] ONE      = 32'd1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_MARK2,
        ST_FIN,
        ST_WPREP,
        ST_WRANGE,
        ST_WREAD,
        ST_WUPD
    } state_t;

    typedef struct packed {
        logic [31:0]              pc;
        logic [31:0]              raw;
        logic [4:0]               meta;
        logic [31:0]              gen1;
        logic [31:0]              gen2;
        logic [PAYLOAD_WIDTH-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic        code;
        logic [31:0] gen;
    } page_t;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic rd;
        logic lk_fin;
        logic st_write;
        logic st_mark2;
        logic w_prep;
        logic w_range;
        logic w_upd;
        logic fin_zero;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic walk_ok;
        logic walk_last;
    } stat_t;

endpackage

/* rtl/core/decoded_insn_cache_page_gen.sv */
// top level of the direct-mapped decoded instruction cache with page generations
`timescale 1ns / 1ps
//
// channel   direction  handshake                 beat
// item      in         start & !busy             kind, fetch_pc, ..., write_size
// result    out        done (one cycle)          hit, decoded_out
// config    in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// lookup reads then evaluates; store also writes the entry and marks the second
// page; unknown kind goes straight to finish; memory write note checks the range
// and walks the pages (one page memory read and, for a code page, one write per
// page; the single page write port sets the pace); after reset a clearing pass
// over 1024 entries zeroes both memories; busy is high, config writes still taken
// results cannot be stalled; one item at a time, busy high until the result
// cycle, when the next item can already be taken
//
module decoded_insn_cache_page_gen (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           kind,
    input  logic [31:0]                          fetch_pc,
    input  logic                                 security,
    input  logic [31:0]                          raw_insn,
    input  logic [2:0]                           insn_len,
    input  logic                                 fpu_enabled,
    input  logic [dicpg_pkg::PAYLOAD_WIDTH-1:0]  decoded_payload,
    input  logic [31:0]                          write_addr,
    input  logic [31:0]                          write_size,
    output logic                                 done,
    output logic                                 hit,
    output logic [dicpg_pkg::PAYLOAD_WIDTH-1:0]  decoded_out,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_index,
    input  logic [31:0]                          cfg_data
);

    dicpg_pkg::cmd_t  cmd;
    dicpg_pkg::stat_t stat;

    // config registers are plain flops, always writable
    assign cfg_ready = 1'b1;

    dicpg_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    dicpg_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fetch_pc        (fetch_pc),
        .security        (security),
        .raw_insn        (raw_insn),
        .insn_len        (insn_len),
        .fpu_enabled     (fpu_enabled),
        .decoded_payload (decoded_payload),
        .write_addr      (write_addr),
        .write_size      (write_size),
        .hit             (hit),
        .decoded_out     (decoded_out),
        .done            (done)
    );

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe held two cycles");
    a_hit_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> done) else $error("hit outside result beat");
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !hit |-> (decoded_out == '0)) else $error("payload on miss");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("not busy after accept");
`endif

endmodule

/* rtl/core/dicpg_ctrl.sv */
// controller state machine sequencing lookup, store, write walk and clear
`timescale 1ns / 1ps
module dicpg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        kind,
    input  dicpg_pkg::stat_t  stat,
    output dicpg_pkg::cmd_t   cmd,
    output logic              busy
);

    dicpg_pkg::state_t state_reg, state_next;
    logic [1:0] kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dicpg_pkg::ST_CLEAR;
            kind_reg  <= dicpg_pkg::KIND_LOOKUP;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            dicpg_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                    state_next = dicpg_pkg::ST_IDLE;
            end
            dicpg_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    kind_next  = kind;
                    case (kind)
                        dicpg_pkg::KIND_LOOKUP,
                        dicpg_pkg::KIND_STORE: state_next = dicpg_pkg::ST_READ;
                        dicpg_pkg::KIND_WRITE: state_next = dicpg_pkg::ST_WPREP;
                        default:               state_next = dicpg_pkg::ST_FIN;
                    endcase
                end
            end
            dicpg_pkg::ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = dicpg_pkg::ST_EVAL;
            end
            dicpg_pkg::ST_EVAL:
            begin
                if (kind_reg == dicpg_pkg::KIND_LOOKUP)
                begin
                    cmd.lk_fin = 1'b1;
                    state_next = dicpg_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.st_write = 1'b1;
                    state_next   = dicpg_pkg::ST_MARK2;
                end
            end
            dicpg_pkg::ST_MARK2:
            begin
                cmd.st_mark2 = 1'b1;
                cmd.fin_zero = 1'b1;
                state_next   = dicpg_pkg::ST_IDLE;
            end
            dicpg_pkg::ST_FIN:
            begin
                cmd.fin_zero = 1'b1;
                state_next   = dicpg_pkg::ST_IDLE;
            end
            dicpg_pkg::ST_WPREP:
            begin
                cmd.w_prep = 1'b1;
                state_next = dicpg_pkg::ST_WRANGE;
            end
            dicpg_pkg::ST_WRANGE:
            begin
                cmd.w_range = 1'b1;
                if (stat.walk_ok)
                    state_next = dicpg_pkg::ST_WREAD;
                else
                begin
                    cmd.fin_zero = 1'b1;
                    state_next   = dicpg_pkg::ST_IDLE;
                end
            end
            dicpg_pkg::ST_WREAD:
            begin
                state_next = dicpg_pkg::ST_WUPD;
            end
            dicpg_pkg::ST_WUPD:
            begin
                cmd.w_upd = 1'b1;
                if (stat.walk_last)
                begin
                    cmd.fin_zero = 1'b1;
                    state_next   = dicpg_pkg::ST_IDLE;
                end
                else
                    state_next = dicpg_pkg::ST_WREAD;
            end
            default:
            begin
                state_next = dicpg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/dicpg_dpath.sv */
// datapath: config registers, entry and page memories, compare and walk logic
`timescale 1ns / 1ps
module dicpg_dpath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dicpg_pkg::cmd_t                      cmd,
    output dicpg_pkg::stat_t                     stat,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_index,
    input  logic [31:0]                          cfg_data,
    input  logic [31:0]                          fetch_pc,
    input  logic                                 security,
    input  logic [31:0]                          raw_insn,
    input  logic [2:0]                           insn_len,
    input  logic                                 fpu_enabled,
    input  logic [dicpg_pkg::PAYLOAD_WIDTH-1:0]  decoded_payload,
    input  logic [31:0]                          write_addr,
    input  logic [31:0]                          write_size,
    output logic                                 hit,
    output logic [dicpg_pkg::PAYLOAD_WIDTH-1:0]  decoded_out,
    output logic                                 done
);

    localparam int EW  = dicpg_pkg::EW;
    localparam int PW  = dicpg_pkg::PW;
    localparam int NW  = dicpg_pkg::NW;
    localparam int PGW = dicpg_pkg::PGW;
    localparam int CW  = dicpg_pkg::CW;
    localparam int PS  = dicpg_pkg::PAGE_SHIFT;

    // configuration
    logic [31:0]  base_reg;
    logic [8:0]   count_reg;
    logic [NW-1:0] live_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                dicpg_pkg::CFG_PAGE_BASE:  base_reg  <= cfg_data;
                dicpg_pkg::CFG_PAGE_COUNT: count_reg <= cfg_data[8:0];
                default:                   base_reg  <= base_reg;
            endcase
        end
    end

    assign live_n = (32'(count_reg) > 32'(dicpg_pkg::MAX_PAGES))
                  ? NW'(dicpg_pkg::MAX_PAGES) : NW'(count_reg);

    // latched item
    logic [31:0] pc_reg, raw_reg, waddr_reg, wsize_reg;
    logic        sec_reg, fpu_reg;
    logic [2:0]  len_reg;
    logic [dicpg_pkg::PAYLOAD_WIDTH-1:0] pay_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pc_reg    <= fetch_pc;
            sec_reg   <= security;
            raw_reg   <= raw_insn;
            len_reg   <= insn_len;
            fpu_reg   <= fpu_enabled;
            pay_reg   <= decoded_payload;
            waddr_reg <= write_addr;
            wsize_reg <= write_size;
        end
    end

    // page numbers of the instruction halves
    logic [31:0]    off1, off2;
    logic [PGW-1:0] p1_reg, p2_reg;
    logic           below_reg;

    assign off1 = pc_reg - base_reg;
    assign off2 = pc_reg + dicpg_pkg::PC_HALF - base_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            p1_reg    <= PGW'(off1 >> PS);
            p2_reg    <= PGW'(off2 >> PS);
            below_reg <= (pc_reg < base_reg);
        end
    end

    // write walk range
    logic [31:0]    wend_reg, offa, offe, first32, last32, n32;
    logic [PW-1:0]  cur_reg, last_reg;

    assign offa    = waddr_reg - base_reg;
    assign offe    = wend_reg - base_reg;
    assign first32 = offa >> PS;
    assign last32  = offe >> PS;
    assign n32     = 32'(live_n);

    always_ff @(posedge clk)
    begin
        if (cmd.w_prep)
            wend_reg <= waddr_reg + wsize_reg - dicpg_pkg::ONE;
        if (cmd.w_range)
        begin
            cur_reg  <= PW'(first32);
            last_reg <= (last32 >= n32) ? PW'(n32 - dicpg_pkg::ONE) : PW'(last32);
        end
        else if (cmd.w_upd)
            cur_reg <= cur_reg + PW'(1);
    end

    assign stat.walk_ok = (live_n != '0) && (wsize_reg != '0) && (waddr_reg >= base_reg)
                        && (first32 < n32) && (last32 >= first32);
    assign stat.walk_last = (cur_reg == last_reg);

    // clearing pass
    logic [CW-1:0] clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clr_step)
            clr_reg <= clr_reg + CW'(1);
    end

    assign stat.clr_done = (32'(clr_reg) == 32'(dicpg_pkg::CLR_LEN - 1));

    // memories
    dicpg_pkg::entry_t ent_mem_reg [dicpg_pkg::CACHE_ENTRIES];
    dicpg_pkg::page_t  pg_mem_reg  [dicpg_pkg::MAX_PAGES];
    dicpg_pkg::entry_t ent_rd_reg;
    dicpg_pkg::page_t  pg_rd0_reg, pg_rd1_reg;

    logic [EW-1:0] slot;
    logic [PW-1:0] pg_ra0, pg_ra1;

    assign slot   = pc_reg[EW:1];
    assign pg_ra0 = cmd.rd ? PW'(off1 >> PS) : cur_reg;
    assign pg_ra1 = PW'(off2 >> PS);

    // tag and generation checks
    logic       in1, in2, word, tag_eq, gen_ok, lk_hit;
    logic [4:0] meta;

    assign meta   = {fpu_reg, len_reg, sec_reg};
    assign word   = (len_reg == dicpg_pkg::LEN_WORD);
    assign in1    = (live_n != '0) && !below_reg && (32'(p1_reg) < n32);
    assign in2    = (live_n != '0) && !below_reg && (32'(p2_reg) < n32);
    assign tag_eq = (ent_rd_reg.pc == pc_reg) && (ent_rd_reg.raw == raw_reg)
                  && (ent_rd_reg.meta == meta);
    assign gen_ok = in1 && (ent_rd_reg.gen1 == pg_rd0_reg.gen)
                  && (!word || (p2_reg == p1_reg)
                      || (in2 && (ent_rd_reg.gen2 == pg_rd1_reg.gen)));
    assign lk_hit = tag_eq && ((live_n == '0) || gen_ok);

    // write port muxes
    logic              ent_we, pg_we;
    logic [EW-1:0]     ent_wa;
    logic [PW-1:0]     pg_wa;
    dicpg_pkg::entry_t ent_wd;
    dicpg_pkg::page_t  pg_wd;

    always_comb
    begin
        ent_we = 1'b0;
        ent_wa = slot;
        ent_wd = '0;
        pg_we  = 1'b0;
        pg_wa  = p1_reg[PW-1:0];
        pg_wd  = '0;
        if (cmd.clr_step)
        begin
            ent_we = (32'(clr_reg) < 32'(dicpg_pkg::CACHE_ENTRIES));
            ent_wa = clr_reg[EW-1:0];
            pg_we  = (32'(clr_reg) < 32'(dicpg_pkg::MAX_PAGES));
            pg_wa  = clr_reg[PW-1:0];
        end
        else if (cmd.st_write)
        begin
            ent_we         = 1'b1;
            ent_wd.pc      = pc_reg;
            ent_wd.raw     = raw_reg;
            ent_wd.meta    = meta;
            ent_wd.gen1    = in1 ? pg_rd0_reg.gen : '0;
            ent_wd.gen2    = (word && in2) ? pg_rd1_reg.gen : '0;
            ent_wd.payload = pay_reg;
            pg_we          = in1;
            pg_wd          = '{code: 1'b1, gen: pg_rd0_reg.gen};
        end
        else if (cmd.st_mark2)
        begin
            pg_we = word && in2;
            pg_wa = p2_reg[PW-1:0];
            pg_wd = '{code: 1'b1, gen: pg_rd1_reg.gen};
        end
        else if (cmd.w_upd)
        begin
            pg_we = pg_rd0_reg.code;
            pg_wa = cur_reg;
            pg_wd = '{code: 1'b1, gen: pg_rd0_reg.gen + dicpg_pkg::ONE};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem_reg[ent_wa] <= ent_wd;
        ent_rd_reg <= ent_mem_reg[slot];
    end

    always_ff @(posedge clk)
    begin
        if (pg_we)
            pg_mem_reg[pg_wa] <= pg_wd;
        pg_rd0_reg <= pg_mem_reg[pg_ra0];
        pg_rd1_reg <= pg_mem_reg[pg_ra1];
    end

    // result registers
    logic done_reg, hit_reg;
    logic [dicpg_pkg::PAYLOAD_WIDTH-1:0] data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            hit_reg  <= 1'b0;
            data_reg <= '0;
        end
        else
        begin
            done_reg <= cmd.lk_fin || cmd.fin_zero;
            hit_reg  <= cmd.lk_fin && lk_hit;
            data_reg <= (cmd.lk_fin && lk_hit) ? ent_rd_reg.payload : '0;
        end
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign decoded_out = data_reg;

endmodule

/* tb/tb_decoded_insn_cache_page_gen.sv */
// testbench for the decoded instruction cache with page generation tracking
`timescale 1ns / 1ps
module tb_decoded_insn_cache_page_gen;

    // kind code that the block treats as a no-op
    localparam logic [1:0] KIND_NOP = 2'd3;
    localparam int         N_PHASES = 5;
    localparam int         PHASE_ITEMS = 226;

    // one request beat as driven onto the item ports
    typedef struct packed {
        logic [1:0]                          kind;
        logic [31:0]                         pc;
        logic                                sec;
        logic [31:0]                         raw;
        logic [2:0]                          len;
        logic                                fpu;
        logic [dicpg_pkg::PAYLOAD_WIDTH-1:0] payload;
        logic [31:0]                         waddr;
        logic [31:0]                         wsize;
    } cache_req_t;

    // predicts lookup results from its own copy of the tag store and page table
    class icache_scoreboard;
        logic [31:0]                         base_reg;
        logic [8:0]                          count_reg;
        logic [31:0]                         tag_pc    [dicpg_pkg::CACHE_ENTRIES];
        logic [31:0]                         tag_raw   [dicpg_pkg::CACHE_ENTRIES];
        logic [4:0]                          tag_meta  [dicpg_pkg::CACHE_ENTRIES];
        logic [31:0]                         gen_lo    [dicpg_pkg::CACHE_ENTRIES];
        logic [31:0]                         gen_hi    [dicpg_pkg::CACHE_ENTRIES];
        logic [dicpg_pkg::PAYLOAD_WIDTH-1:0] payload_q [dicpg_pkg::CACHE_ENTRIES];
        logic [31:0]                         page_epoch [dicpg_pkg::MAX_PAGES];
        logic                                page_code [dicpg_pkg::MAX_PAGES];
        logic [dicpg_pkg::PAYLOAD_WIDTH:0]   expected_results[$];
        int                                  mismatches;
        int                                  results_seen;
        int                                  hits_seen;
        int                                  page_bumps;

        function new();
            base_reg = '0;
            count_reg = '0;
            mismatches = 0;
            results_seen = 0;
            hits_seen = 0;
            page_bumps = 0;
            foreach (tag_pc[i])
            begin
                tag_pc[i] = '0;
                tag_raw[i] = '0;
                tag_meta[i] = '0;
                gen_lo[i] = '0;
                gen_hi[i] = '0;
                payload_q[i] = '0;
            end
            foreach (page_epoch[i])
            begin
                page_epoch[i] = '0;
                page_code[i] = 1'b0;
            end
        endfunction

        function void write_reg(logic idx, logic [31:0] data);
            if (idx == dicpg_pkg::CFG_PAGE_BASE)
                base_reg = data;
            else
                count_reg = data[8:0];
        endfunction

        function int unsigned tracked_pages();
            return (count_reg > dicpg_pkg::MAX_PAGES) ? dicpg_pkg::MAX_PAGES : count_reg;
        endfunction

        function logic [31:0] page_index(logic [31:0] addr);
            logic [31:0] delta;
            delta = addr - base_reg;
            return delta >> dicpg_pkg::PAGE_SHIFT;
        endfunction

        // apply one accepted beat and queue the result it should produce
        function void note_request(cache_req_t r);
            int unsigned n;
            logic [dicpg_pkg::EW-1:0] slot;
            logic [4:0] meta;
            logic [31:0] p1, p2, first, last;
            logic found;
            logic [dicpg_pkg::PAYLOAD_WIDTH-1:0] data;
            n = tracked_pages();
            slot = r.pc[dicpg_pkg::EW:1];
            meta = {r.fpu, r.len, r.sec};
            found = 1'b0;
            data = '0;
            if (r.kind == dicpg_pkg::KIND_LOOKUP)
            begin
                found = tag_pc[slot] == r.pc && tag_raw[slot] == r.raw
                        && tag_meta[slot] == meta;
                if (found && n != 0)
                begin
                    if (r.pc < base_reg)
                        found = 1'b0;
                    else
                    begin
                        p1 = page_index(r.pc);
                        if (p1 >= n)
                            found = 1'b0;
                        else if (gen_lo[slot] != page_epoch[p1])
                            found = 1'b0;
                        else if (r.len == dicpg_pkg::LEN_WORD)
                        begin
                            p2 = page_index(r.pc + dicpg_pkg::PC_HALF);
                            if (p2 != p1)
                            begin
                                if (p2 >= n)
                                    found = 1'b0;
                                else if (gen_hi[slot] != page_epoch[p2])
                                    found = 1'b0;
                            end
                        end
                    end
                end
                if (found)
                    data = payload_q[slot];
            end
            else if (r.kind == dicpg_pkg::KIND_STORE)
            begin
                tag_pc[slot] = r.pc;
                tag_raw[slot] = r.raw;
                tag_meta[slot] = meta;
                gen_lo[slot] = '0;
                gen_hi[slot] = '0;
                payload_q[slot] = r.payload;
                if (n != 0 && r.pc >= base_reg)
                begin
                    p1 = page_index(r.pc);
                    if (p1 < n)
                    begin
                        gen_lo[slot] = page_epoch[p1];
                        page_code[p1] = 1'b1;
                    end
                    if (r.len == dicpg_pkg::LEN_WORD)
                    begin
                        p2 = page_index(r.pc + dicpg_pkg::PC_HALF);
                        if (p2 < n)
                        begin
                            gen_hi[slot] = page_epoch[p2];
                            page_code[p2] = 1'b1;
                        end
                    end
                end
            end
            else if (r.kind == dicpg_pkg::KIND_WRITE)
            begin
                if (n != 0 && r.wsize != 0 && r.waddr >= base_reg)
                begin
                    first = page_index(r.waddr);
                    last = page_index(r.waddr + r.wsize - dicpg_pkg::ONE);
                    if (first < n)
                    begin
                        if (last >= n)
                            last = n - 1;
                        for (int unsigned i = first; i <= last; i++)
                        begin
                            if (page_code[i])
                            begin
                                page_epoch[i] = page_epoch[i] + dicpg_pkg::ONE;
                                page_bumps++;
                            end
                        end
                    end
                end
            end
            expected_results.push_back({found, data});
        endfunction

        function void check_result(logic h, logic [dicpg_pkg::PAYLOAD_WIDTH-1:0] d);
            logic [dicpg_pkg::PAYLOAD_WIDTH:0] exp_r;
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result beat with nothing pending: hit=%0b data=%h", h, d);
                return;
            end
            exp_r = expected_results.pop_front();
            if (exp_r[dicpg_pkg::PAYLOAD_WIDTH])
                hits_seen++;
            if (h !== exp_r[dicpg_pkg::PAYLOAD_WIDTH]
                || d !== exp_r[dicpg_pkg::PAYLOAD_WIDTH-1:0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d: expected hit=%0b data=%h, got hit=%0b data=%h",
                             results_seen, exp_r[dicpg_pkg::PAYLOAD_WIDTH],
                             exp_r[dicpg_pkg::PAYLOAD_WIDTH-1:0], h, d);
            end
        endfunction
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                start = 1'b0;
    logic                                busy;
    logic [1:0]                          kind = '0;
    logic [31:0]                         fetch_pc = '0;
    logic                                security = 1'b0;
    logic [31:0]                         raw_insn = '0;
    logic [2:0]                          insn_len = '0;
    logic                                fpu_enabled = 1'b0;
    logic [dicpg_pkg::PAYLOAD_WIDTH-1:0] decoded_payload = '0;
    logic [31:0]                         write_addr = '0;
    logic [31:0]                         write_size = '0;
    logic                                done;
    logic                                hit;
    logic [dicpg_pkg::PAYLOAD_WIDTH-1:0] decoded_out;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic                                cfg_index = 1'b0;
    logic [31:0]                         cfg_data = '0;

    icache_scoreboard sb = new();

    // tb-side copy of the config, used only to aim stimulus at tracked pages
    logic [31:0] aim_base = '0;
    int unsigned aim_pages = 0;
    // recently stored tags, replayed by lookups and later stores
    cache_req_t recent_stores[$];

    decoded_insn_cache_page_gen dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .kind(kind),
        .fetch_pc(fetch_pc),
        .security(security),
        .raw_insn(raw_insn),
        .insn_len(insn_len),
        .fpu_enabled(fpu_enabled),
        .decoded_payload(decoded_payload),
        .write_addr(write_addr),
        .write_size(write_size),
        .done(done),
        .hit(hit),
        .decoded_out(decoded_out),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // monitor: results are checked before the beat accepted at the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(hit, decoded_out);
            if (start && !busy)
                sb.note_request({kind, fetch_pc, security, raw_insn, insn_len, fpu_enabled,
                                 decoded_payload, write_addr, write_size});
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
        end
    end

    // drive one beat and hold it until busy is low at a sampling edge
    task automatic send_request(cache_req_t r, int idle_pct);
        kind <= r.kind;
        fetch_pc <= r.pc;
        security <= r.sec;
        raw_insn <= r.raw;
        insn_len <= r.len;
        fpu_enabled <= r.fpu;
        decoded_payload <= r.payload;
        write_addr <= r.waddr;
        write_size <= r.wsize;
        start <= 1'b1;
        forever
        begin
            @(negedge clk);
            if (!busy)
                break;
            @(posedge clk);
        end
        @(posedge clk);
        // random gaps between beats; without one, start simply stays high
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // leaves cfg_valid high; the caller drops it after its last write
    task automatic write_cfg(logic idx, logic [31:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        forever
        begin
            @(negedge clk);
            if (cfg_ready)
                break;
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    // sender pauses until every pending result beat is back
    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        // let the monitor note the beat accepted at this edge
        @(posedge clk);
        while (sb.expected_results.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_window(logic [31:0] base, logic [8:0] count);
        drain();
        write_cfg(dicpg_pkg::CFG_PAGE_BASE, base);
        write_cfg(dicpg_pkg::CFG_PAGE_COUNT, {23'd0, count});
        cfg_valid <= 1'b0;
        aim_base = base;
        aim_pages = (count > dicpg_pkg::MAX_PAGES) ? dicpg_pkg::MAX_PAGES : count;
    endtask

    function automatic cache_req_t make_req(logic [1:0] k, logic [31:0] pc, logic [2:0] len,
                                            logic [31:0] raw);
        cache_req_t r;
        r = '0;
        r.kind = k;
        r.pc = pc;
        r.len = len;
        r.raw = raw;
        return r;
    endfunction

    // address aimed inside or just past the tracked window, often near a page end
    function automatic logic [31:0] aimed_addr();
        logic [31:0] pg, off;
        pg = $urandom_range(0, aim_pages);
        case ($urandom_range(0, 3))
            0: off = 32'hFFE;
            1: off = 32'hFFC;
            default: off = $urandom_range(0, 4095);
        endcase
        return aim_base + (pg << dicpg_pkg::PAGE_SHIFT) + off;
    endfunction

    function automatic cache_req_t random_req();
        cache_req_t r;
        int pick;
        r.kind = dicpg_pkg::KIND_LOOKUP;
        r.pc = $urandom;
        r.sec = $urandom_range(0, 1);
        r.raw = $urandom;
        r.len = ($urandom_range(0, 9) < 7)
              ? ($urandom_range(0, 1) ? dicpg_pkg::LEN_WORD : 3'd2)
              : 3'($urandom_range(0, 7));
        r.fpu = $urandom_range(0, 1);
        r.payload = {$urandom, $urandom};
        r.waddr = $urandom;
        r.wsize = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            r.kind = dicpg_pkg::KIND_LOOKUP;
            if (recent_stores.size() != 0 && $urandom_range(0, 9) < 6)
            begin
                cache_req_t s;
                s = recent_stores[$urandom_range(0, recent_stores.size() - 1)];
                r.pc = s.pc;
                r.sec = s.sec;
                r.raw = s.raw;
                r.len = s.len;
                r.fpu = s.fpu;
                // occasionally spoil one tag field
                if ($urandom_range(0, 9) == 0)
                    r.sec = ~r.sec;
                else if ($urandom_range(0, 9) == 0)
                    r.raw[$urandom_range(0, 31)] ^= 1'b1;
            end
            else if ($urandom_range(0, 9) < 8)
                r.pc = aimed_addr();
        end
        else if (pick < 75)
        begin
            r.kind = dicpg_pkg::KIND_STORE;
            if (recent_stores.size() != 0 && $urandom_range(0, 9) < 3)
            begin
                cache_req_t s;
                s = recent_stores[$urandom_range(0, recent_stores.size() - 1)];
                r.pc = s.pc;
                r.sec = s.sec;
                r.raw = s.raw;
                r.len = s.len;
                r.fpu = s.fpu;
            end
            else if ($urandom_range(0, 9) < 8)
                r.pc = aimed_addr();
            recent_stores.push_back(r);
            if (recent_stores.size() > 64)
                void'(recent_stores.pop_front());
        end
        else if (pick < 93)
        begin
            r.kind = dicpg_pkg::KIND_WRITE;
            if ($urandom_range(0, 9) < 9)
                r.waddr = aimed_addr();
            pick = $urandom_range(0, 99);
            // long page walks are slow, keep them rare
            if (pick < 80)
                r.wsize = $urandom_range(1, 64);
            else if (pick < 95)
                r.wsize = $urandom_range(0, 3 * 4096);
            else if (pick < 98)
                r.wsize = $urandom;
        end
        else
            r.kind = KIND_NOP;
        return r;
    endfunction

    initial
    begin
        int idle_pcts[N_PHASES];
        logic [31:0] bases[N_PHASES];
        logic [8:0] counts[N_PHASES];
        cache_req_t r;
        int guard;
        int items_sent;
        idle_pcts = '{0, 63, 0, 31, 63};
        bases = '{32'h0000_0000, 32'h8000_3000, 32'hFFFF_F000, 32'h0004_0000, 32'h1234_5000};
        // includes the largest count (clipped to the page limit) and tracking off
        counts = '{9'd256, 9'd3, 9'd511, 9'd0, 9'd1};
        items_sent = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: tracking off after reset
        // an all-zero lookup matches a cleared entry
        send_request(make_req(dicpg_pkg::KIND_LOOKUP, 32'h0, 3'd0, 32'h0), 0);
        r = '1;
        r.kind = dicpg_pkg::KIND_LOOKUP;
        send_request(r, 0);
        r.kind = dicpg_pkg::KIND_STORE;
        send_request(r, 0);
        r.kind = dicpg_pkg::KIND_LOOKUP;
        send_request(r, 0);
        r.kind = KIND_NOP;
        send_request(r, 0);
        // memory writes are ignored with tracking off
        r.kind = dicpg_pkg::KIND_WRITE;
        send_request(r, 0);
        r.kind = dicpg_pkg::KIND_LOOKUP;
        send_request(r, 0);
        items_sent += 7;

        // directed: four tracked pages starting at 0x1000
        set_window(32'h0000_1000, 9'd4);
        // 4-byte instruction crossing a page boundary
        r = make_req(dicpg_pkg::KIND_STORE, 32'h0000_1FFE, dicpg_pkg::LEN_WORD, 32'hCAFE_F00D);
        r.payload = 64'h0123_4567_89AB_CDEF;
        send_request(r, 0);
        r.kind = dicpg_pkg::KIND_LOOKUP;
        send_request(r, 0);
        // zero-size write and write below base are ignored
        send_request('{kind: dicpg_pkg::KIND_WRITE, waddr: 32'h0000_2000, wsize: 32'd0,
                       default: '0}, 0);
        send_request('{kind: dicpg_pkg::KIND_WRITE, waddr: 32'h0000_0FFF, wsize: 32'd1,
                       default: '0}, 0);
        send_request(r, 0);
        // write touching only the second page invalidates the entry
        send_request('{kind: dicpg_pkg::KIND_WRITE, waddr: 32'h0000_2000, wsize: 32'd1,
                       default: '0}, 0);
        send_request(r, 0);
        // store below base records generation 0 and misses on lookup
        r = make_req(dicpg_pkg::KIND_STORE, 32'h0000_0800, 3'd2, 32'h1111_2222);
        send_request(r, 0);
        r.kind = dicpg_pkg::KIND_LOOKUP;
        send_request(r, 0);
        // store past the last tracked page, then a write starting beyond the pages
        r = make_req(dicpg_pkg::KIND_STORE, 32'h0000_5000, 3'd2, 32'h3333_4444);
        send_request(r, 0);
        r.kind = dicpg_pkg::KIND_LOOKUP;
        send_request(r, 0);
        send_request('{kind: dicpg_pkg::KIND_WRITE, waddr: 32'h0000_5000, wsize: 32'd4,
                       default: '0}, 0);
        // wrapping write whose end page precedes its start page
        send_request('{kind: dicpg_pkg::KIND_WRITE, waddr: 32'h0000_3000, wsize: 32'hFFFF_F000,
                       default: '0}, 0);
        // write running past the last page is clipped
        send_request('{kind: dicpg_pkg::KIND_WRITE, waddr: 32'h0000_1000, wsize: 32'h0010_0000,
                       default: '0}, 0);
        items_sent += 14;

        // random phases, each with its own window and sender idling
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            set_window(bases[ph], counts[ph]);
            recent_stores.delete();
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_request(random_req(), idle_pcts[ph]);
                items_sent++;
            end
        end

        start <= 1'b0;
        guard = 0;
        @(posedge clk);
        while (sb.expected_results.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (600) @(posedge clk);

        // anything still pending counts as a failure
        sb.mismatches += sb.expected_results.size();
        $display("covered %0d beats over %0d windows: %0d results, %0d hits, %0d page bumps",
                 items_sent, N_PHASES + 2, sb.results_seen, sb.hits_seen, sb.page_bumps);
        $display("mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // run limit well above the slowest legal run
    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule
